// ===== design/matrix_inverse_by_adjugate_top_assert.svh =====
// Assertion macros for the matrix inverse block.
// Each macro takes a label, the clock, the active low reset, a condition and a consequence.
`ifndef MATRIX_INVERSE_BY_ADJUGATE_TOP_ASSERT_SVH
`define MATRIX_INVERSE_BY_ADJUGATE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define MIA_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define MIA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MIA_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define MIA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== design/mia_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mia_pkg;

    localparam int MAX_SIZE_DEF      = 4;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int ELEM_W = 12;
    localparam int ADJ_W  = 37;
    localparam int INV_W  = 54;
    localparam int DET_W  = 50;
    localparam int IDX_W  = 2;
    localparam int CFG_W  = 3;
    localparam int LC_W   = 5;

    localparam logic [CFG_W-1:0] SIZE_RESET = 3'd4;
    localparam logic [LC_W-1:0]  LC_SAT     = 5'd31;

    // Permutations of three minor columns, used for the explicit determinant sum.
    localparam int PERM_COUNT = 6;
    localparam int PERM_LEN   = 3;
    localparam logic [1:0] PERM_TABLE [PERM_COUNT][PERM_LEN] = '{
        '{2'd0, 2'd1, 2'd2},
        '{2'd0, 2'd2, 2'd1},
        '{2'd1, 2'd0, 2'd2},
        '{2'd1, 2'd2, 2'd0},
        '{2'd2, 2'd0, 2'd1},
        '{2'd2, 2'd1, 2'd0}
    };
    localparam logic [PERM_COUNT-1:0] PERM_ODD = 6'b100110;
    localparam logic [2:0] PERM_LAST = 3'd5;

    localparam logic [2:0] TERM_STEP_LAST = 3'd4;
    localparam logic [2:0] DET_STEP_LAST  = 3'd2;
    localparam logic [2:0] FETCH_STEP_LAST = 3'd1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_TERM,
        ST_DET,
        ST_CHECK,
        ST_FETCH,
        ST_DIV,
        ST_PACK,
        ST_OUT
    } t_state;

    function automatic logic [1:0] perm_entry(input logic [2:0] idx, input logic [2:0] pos);
        logic [1:0] v;
        v = 2'd0;
        if (idx < 3'(PERM_COUNT) && pos < 3'(PERM_LEN)) begin
            v = PERM_TABLE[idx][pos[1:0]];
        end
        return v;
    endfunction

    // A permutation contributes to an m by m minor only if it fixes every position at or above m.
    function automatic logic term_valid(input logic [2:0] idx, input logic [2:0] m);
        logic ok;
        ok = 1'b1;
        for (int p = 0; p < PERM_LEN; p++) begin
            if (3'(p) >= m && 3'(perm_entry(idx, 3'(p))) != 3'(p)) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage
`default_nettype wire

// ===== design/matrix_inverse_by_adjugate_top.sv =====
// While loading, input is always ready. After the final element the block works out the
// cofactors, then the determinant, then the zero check, and then for each result beat it
// fetches a cofactor, divides and packs (one bit of the quotient per cycle in the shared
// restoring divider). A singular matrix goes straight from the zero check to its one beat.
// Throughput: one matrix at a time; input is not ready from the final element until the last
// result beat is taken. Reset (synchronous, active low) sets N to 4 and the load count to zero.
`timescale 1ns / 1ps
`default_nettype none
module matrix_inverse_by_adjugate_top
    import mia_pkg::*;
#(
    parameter int MAX_SIZE      = MAX_SIZE_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [CFG_W-1:0]         i_cfg_data,
    input  wire logic                     i_element_valid,
    output logic                          o_element_ready,
    input  wire logic signed [ELEM_W-1:0] i_element,
    output logic                          o_result_valid,
    input  wire logic                     i_result_ready,
    output logic [IDX_W-1:0]              o_row,
    output logic [IDX_W-1:0]              o_column,
    output logic signed [ADJ_W-1:0]       o_adjugate_entry,
    output logic signed [INV_W-1:0]       o_inverse_entry,
    output logic signed [DET_W-1:0]       o_determinant_value,
    output logic                          o_singular,
    output logic                          o_last
);

    `include "matrix_inverse_by_adjugate_top_assert.svh"

    // The matrix is kept row-major at linear positions, as it arrives. Cofactors are kept
    // at row*MAX_SIZE+column. All multiplication goes through one 37 by 12 bit multiplier:
    // each cofactor is an explicit sum over up to six permutation terms, each term taking
    // one read per factor, and the determinant is the first row dotted with its cofactors.
    localparam int CELLS  = MAX_SIZE * MAX_SIZE;
    localparam int AW     = $clog2(CELLS);
    localparam int IW     = $clog2(MAX_SIZE);
    localparam int PROD_W = ADJ_W + ELEM_W;
    localparam int DW     = ADJ_W + FRACTION_BITS;
    localparam int CW     = $clog2(DW + 1);
    localparam logic [CFG_W-1:0] N_MAX = CFG_W'(MAX_SIZE);

    t_state r_state, n_state;

    logic [CFG_W-1:0] r_size;
    logic [LC_W-1:0]  r_lc;
    logic [IW-1:0]    r_cr, r_cc;
    logic [2:0]       r_perm, r_k;
    logic [CW-1:0]    r_cnt;

    logic signed [ELEM_W-1:0] mem_mat [CELLS];
    logic signed [ADJ_W-1:0]  mem_cof [CELLS];
    logic signed [ELEM_W-1:0] r_mat_rd;
    logic signed [ADJ_W-1:0]  r_cof_rd;
    logic                     r_unit;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [ADJ_W-1:0]  r_acc;
    logic signed [DET_W-1:0]  r_det;
    logic [DET_W-1:0]         r_rem;
    logic [DET_W-1:0]         r_dmag;
    logic [DW-1:0]            r_quo;
    logic                     r_qneg;
    logic signed [ADJ_W-1:0]  r_adj;

    logic [IDX_W-1:0]         r_o_row, r_o_col;
    logic signed [ADJ_W-1:0]  r_o_adj;
    logic signed [INV_W-1:0]  r_o_inv;
    logic signed [DET_W-1:0]  r_o_det;
    logic                     r_o_sing, r_o_last;

    // Effective order: zero reads as one, anything above the maximum as the maximum.
    logic [CFG_W-1:0] n_eff, n_m1;
    logic [LC_W-1:0]  nn, lc_inc;
    logic             elem_acc, load_done, last_c, last_r;

    always_comb begin
        n_eff = r_size;
        if (r_size == '0) begin
            n_eff = CFG_W'(1);
        end else if (r_size > N_MAX) begin
            n_eff = N_MAX;
        end
    end
    assign n_m1      = n_eff - CFG_W'(1);
    assign nn        = LC_W'(n_eff) * LC_W'(n_eff);
    assign lc_inc    = (r_lc < LC_SAT) ? r_lc + LC_W'(1) : r_lc;
    assign elem_acc  = i_element_valid && o_element_ready;
    assign load_done = elem_acc && (lc_inc >= nn);
    assign last_c    = (CFG_W'(r_cc) == n_m1);
    assign last_r    = (CFG_W'(r_cr) == n_m1);

    // Address of factor r_k of the current term: row r_k of the minor and column
    // picked by the permutation, both stepping over the cofactor's own row and column.
    logic [2:0]  f_row, f_col;
    logic [1:0]  f_pcol;
    logic [LC_W-1:0] f_lin;
    logic        f_unit, t_valid, t_odd, cof_odd;
    logic signed [ELEM_W-1:0] fval;
    logic signed [ADJ_W-1:0]  acc_nx, cof_wval;
    logic        cof_we;

    assign f_row   = (r_k < 3'(r_cr)) ? r_k : r_k + 3'd1;
    assign f_pcol  = perm_entry(r_perm, r_k);
    assign f_col   = (3'(f_pcol) < 3'(r_cc)) ? 3'(f_pcol) : 3'(f_pcol) + 3'd1;
    assign f_lin   = LC_W'(f_row) * LC_W'(n_eff) + LC_W'(f_col);
    assign f_unit  = (r_k >= n_m1);
    assign t_valid = term_valid(r_perm, n_m1);
    assign t_odd   = PERM_ODD[r_perm];
    assign cof_odd = r_cr[0] ^ r_cc[0];
    assign fval    = r_unit ? ELEM_W'(1) : r_mat_rd;

    always_comb begin
        acc_nx = r_acc;
        if (t_valid) begin
            acc_nx = t_odd ? r_acc - signed'(r_prod[ADJ_W-1:0])
                           : r_acc + signed'(r_prod[ADJ_W-1:0]);
        end
    end
    assign cof_wval = cof_odd ? -acc_nx : acc_nx;
    assign cof_we   = (r_state == ST_TERM) && (r_k == TERM_STEP_LAST) && (r_perm == PERM_LAST);

    // The shared multiplier.
    logic signed [ADJ_W-1:0]  mul_a;
    logic signed [ELEM_W-1:0] mul_b;
    logic signed [PROD_W-1:0] mul_y;
    assign mul_a = (r_state == ST_DET) ? r_cof_rd : signed'(r_prod[ADJ_W-1:0]);
    assign mul_b = (r_state == ST_DET) ? r_mat_rd : fval;
    assign mul_y = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Memory addresses.
    logic [AW-1:0] mat_raddr, cof_raddr, cof_waddr, mat_waddr;
    always_comb begin
        mat_raddr = AW'(f_lin);
        cof_raddr = AW'(r_cc);
        if (r_state == ST_DET) begin
            mat_raddr = AW'(r_cc);
        end
        if (r_state == ST_FETCH) begin
            cof_raddr = AW'(LC_W'(r_cc) * LC_W'(MAX_SIZE) + LC_W'(r_cr));
        end
    end
    assign cof_waddr = AW'(LC_W'(r_cr) * LC_W'(MAX_SIZE) + LC_W'(r_cc));
    assign mat_waddr = AW'(r_lc);

    always_ff @(posedge i_clk) begin
        if (elem_acc && r_lc < LC_W'(CELLS)) begin
            mem_mat[mat_waddr] <= i_element;
        end
        if (cof_we) begin
            mem_cof[cof_waddr] <= cof_wval;
        end
        r_mat_rd <= mem_mat[mat_raddr];
        r_cof_rd <= mem_cof[cof_raddr];
        r_unit   <= f_unit;
    end

    // Divider step: one quotient bit per cycle on magnitudes.
    logic [DET_W:0]  div_t;
    logic            div_ge;
    logic [DET_W-1:0] det_mag;
    logic [ADJ_W-1:0] adj_mag;
    logic [DW-1:0]    quo_s;
    assign div_t   = {r_rem, r_quo[DW-1]};
    assign div_ge  = div_t >= {1'b0, r_dmag};
    assign det_mag = r_det[DET_W-1] ? DET_W'(-r_det) : DET_W'(r_det);
    assign adj_mag = r_cof_rd[ADJ_W-1] ? ADJ_W'(-r_cof_rd) : ADJ_W'(r_cof_rd);
    assign quo_s   = DW'(adj_mag) << FRACTION_BITS;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (load_done) n_state = ST_TERM;
            end
            ST_TERM: begin
                if (cof_we && last_c && last_r) n_state = ST_DET;
            end
            ST_DET: begin
                if (r_k == DET_STEP_LAST && last_c) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                n_state = (r_det == '0) ? ST_OUT : ST_FETCH;
            end
            ST_FETCH: begin
                if (r_k == FETCH_STEP_LAST) n_state = ST_DIV;
            end
            ST_DIV: begin
                if (r_cnt == CW'(DW - 1)) n_state = ST_PACK;
            end
            ST_PACK: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_result_ready) n_state = r_o_last ? ST_LOAD : ST_FETCH;
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // Handshake outputs. The order register only changes while elements are being loaded,
    // so a write can never disturb a matrix that is being worked on.
    always_comb begin
        o_cfg_ready     = 1'b0;
        o_element_ready = 1'b0;
        o_result_valid  = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                o_cfg_ready     = 1'b1;
                o_element_ready = 1'b1;
            end
            ST_OUT:  o_result_valid  = 1'b1;
            default: begin
                o_element_ready = 1'b0;
                o_result_valid  = 1'b0;
            end
        endcase
    end

    // Control registers and loop counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_size  <= SIZE_RESET;
            r_lc    <= '0;
            r_cr    <= '0;
            r_cc    <= '0;
            r_perm  <= '0;
            r_k     <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_size <= i_cfg_data;
            end
            case (r_state)
                ST_LOAD: begin
                    if (elem_acc) begin
                        r_lc <= load_done ? '0 : lc_inc;
                    end
                    r_cr   <= '0;
                    r_cc   <= '0;
                    r_perm <= '0;
                    r_k    <= '0;
                end
                ST_TERM: begin
                    if (r_k == TERM_STEP_LAST) begin
                        r_k <= '0;
                        if (r_perm == PERM_LAST) begin
                            r_perm <= '0;
                            if (last_c) begin
                                r_cc <= '0;
                                r_cr <= last_r ? '0 : r_cr + IW'(1);
                            end else begin
                                r_cc <= r_cc + IW'(1);
                            end
                        end else begin
                            r_perm <= r_perm + 3'd1;
                        end
                    end else begin
                        r_k <= r_k + 3'd1;
                    end
                end
                ST_DET: begin
                    if (r_k == DET_STEP_LAST) begin
                        r_k  <= '0;
                        r_cc <= last_c ? '0 : r_cc + IW'(1);
                    end else begin
                        r_k <= r_k + 3'd1;
                    end
                end
                ST_CHECK: begin
                    r_k  <= '0;
                    r_cr <= '0;
                    r_cc <= '0;
                end
                ST_FETCH: begin
                    r_k   <= (r_k == FETCH_STEP_LAST) ? '0 : r_k + 3'd1;
                    r_cnt <= '0;
                end
                ST_DIV: begin
                    r_cnt <= r_cnt + CW'(1);
                end
                ST_OUT: begin
                    if (i_result_ready) begin
                        if (last_c) begin
                            r_cc <= '0;
                            r_cr <= r_cr + IW'(1);
                        end else begin
                            r_cc <= r_cc + IW'(1);
                        end
                    end
                end
                default: begin
                    r_k <= r_k;
                end
            endcase
        end
    end

    // Arithmetic and result registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_LOAD: begin
                r_acc <= '0;
            end
            ST_TERM: begin
                if (r_k == 3'd1) begin
                    r_prod <= PROD_W'(fval);
                end else if (r_k == 3'd2 || r_k == 3'd3) begin
                    r_prod <= mul_y;
                end else if (r_k == TERM_STEP_LAST) begin
                    r_acc <= (r_perm == PERM_LAST) ? '0 : acc_nx;
                    r_det <= '0;
                end
            end
            ST_DET: begin
                if (r_k == 3'd1) begin
                    r_prod <= mul_y;
                end else if (r_k == DET_STEP_LAST) begin
                    r_det <= r_det + DET_W'(r_prod);
                end
            end
            ST_CHECK: begin
                r_o_row  <= '0;
                r_o_col  <= '0;
                r_o_adj  <= '0;
                r_o_inv  <= '0;
                r_o_det  <= '0;
                r_o_sing <= 1'b1;
                r_o_last <= 1'b1;
            end
            ST_FETCH: begin
                if (r_k == FETCH_STEP_LAST) begin
                    r_adj  <= r_cof_rd;
                    r_quo  <= quo_s;
                    r_rem  <= '0;
                    r_dmag <= det_mag;
                    r_qneg <= r_cof_rd[ADJ_W-1] ^ r_det[DET_W-1];
                end
            end
            ST_DIV: begin
                r_rem <= div_ge ? DET_W'(div_t - {1'b0, r_dmag}) : DET_W'(div_t);
                r_quo <= {r_quo[DW-2:0], div_ge};
            end
            ST_PACK: begin
                r_o_row  <= IDX_W'(r_cr);
                r_o_col  <= IDX_W'(r_cc);
                r_o_adj  <= r_adj;
                r_o_inv  <= r_qneg ? -INV_W'(r_quo) : INV_W'(r_quo);
                r_o_det  <= r_det;
                r_o_sing <= 1'b0;
                r_o_last <= last_r && last_c;
            end
            default: begin
                r_o_last <= r_o_last;
            end
        endcase
    end

    assign o_row               = r_o_row;
    assign o_column            = r_o_col;
    assign o_adjugate_entry    = r_o_adj;
    assign o_inverse_entry     = r_o_inv;
    assign o_determinant_value = r_o_det;
    assign o_singular          = r_o_sing;
    assign o_last              = r_o_last;

    // Loading and presenting results never overlap.
    `MIA_ASSERT_IMPL(a_no_overlap, i_clk, i_rst_n, o_result_valid, !o_element_ready)
    // A singular matrix yields exactly one beat, so it must be the last.
    `MIA_ASSERT_IMPL(a_singular_last, i_clk, i_rst_n, o_result_valid && o_singular, o_last)
    // The divider stops after its final quotient bit.
    `MIA_ASSERT_NEXT(a_div_end, i_clk, i_rst_n, r_state == ST_DIV && r_cnt == CW'(DW - 1),
        r_state == ST_PACK)

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Checks the adjugate matrix inverse block. Elements stream in row-major order.
// A model inside this bench tracks the loaded elements and the configured order N.
// When a matrix is complete, it works out the determinant, every adjugate entry and the
// Q.16 inverse. It then compares each result beat, field by field, against that prediction.
module testbench;
    import mia_pkg::*;

    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 30000;

    typedef struct {
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        column;
        logic signed [ADJ_W-1:0] adjugate;
        logic signed [INV_W-1:0] inverse;
        logic signed [DET_W-1:0] determinant;
        logic                    singular;
        logic                    last;
    } t_inverse_beat;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_valid = 1'b0;
    logic [CFG_W-1:0]         i_cfg_data = '0;
    logic                     i_element_valid = 1'b0;
    logic signed [ELEM_W-1:0] i_element = '0;
    logic                     i_result_ready = 1'b0;
    logic                     o_cfg_ready;
    logic                     o_element_ready;
    logic                     o_result_valid;
    logic [IDX_W-1:0]         o_row;
    logic [IDX_W-1:0]         o_column;
    logic signed [ADJ_W-1:0]  o_adjugate_entry;
    logic signed [INV_W-1:0]  o_inverse_entry;
    logic signed [DET_W-1:0]  o_determinant_value;
    logic                     o_singular;
    logic                     o_last;

    // This is the model's copy of the block state.
    logic [CFG_W-1:0] order_reg = SIZE_RESET;
    longint           element_store [16];
    int unsigned      loaded_count = 0;
    t_inverse_beat    pending_beats [$];

    int  failures = 0;
    bit  quiet = 1'b0;       // When set, neither side inserts gaps.
    bit  hold_request = 1'b0;
    int  watchdog = 0;

    matrix_inverse_by_adjugate_top DUT (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Most gaps are short, and a few are long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 15);
        if (r < 11) return $urandom_range(1, 3);
        if (r < 15) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int order_of(input logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > 4) return 4;
        return int'(v);
    endfunction

    function automatic longint det3(input longint a[4][4]);
        return a[0][0] * (a[1][1] * a[2][2] - a[1][2] * a[2][1])
             - a[0][1] * (a[1][0] * a[2][2] - a[1][2] * a[2][0])
             + a[0][2] * (a[1][0] * a[2][1] - a[1][1] * a[2][0]);
    endfunction

    // This computes the determinant of the leading k by k corner of a.
    // For k = 4, it expands along the first row.
    function automatic longint det_upto4(input longint a[4][4], input int k);
        longint sub[4][4];
        longint acc;
        int     m;
        acc = 0;
        case (k)
            0: acc = 1;
            1: acc = a[0][0];
            2: acc = a[0][0] * a[1][1] - a[0][1] * a[1][0];
            3: acc = det3(a);
            default: begin
                for (int i = 0; i < 4; i++) begin
                    for (int r = 1; r < 4; r++) begin
                        m = 0;
                        for (int c = 0; c < 4; c++) begin
                            if (c != i) begin
                                sub[r-1][m] = a[r][c];
                                m++;
                            end
                        end
                    end
                    if (i % 2 == 1) acc -= a[0][i] * det3(sub);
                    else acc += a[0][i] * det3(sub);
                end
            end
        endcase
        return acc;
    endfunction

    // This takes one accepted element. When the element completes a matrix, the
    // expected result beats are queued.
    function automatic void absorb_element(input logic signed [ELEM_W-1:0] e);
        longint        a[4][4];
        longint        sub[4][4];
        longint        cof[4][4];
        longint        det;
        longint        adj;
        int            n;
        int            mr;
        int            mc;
        t_inverse_beat b;
        n = order_of(order_reg);
        if (loaded_count < 16) element_store[loaded_count] = longint'(e);
        if (loaded_count < 31) loaded_count++;
        if (loaded_count < n * n) return;
        loaded_count = 0;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                a[r][c] = (r < n && c < n) ? element_store[(r * n + c) % 16] : 0;
        det = det_upto4(a, n);
        if (det == 0) begin
            b = '{row: '0, column: '0, adjugate: '0, inverse: '0, determinant: '0,
                  singular: 1'b1, last: 1'b1};
            pending_beats.push_back(b);
            return;
        end
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n; c++) begin
                mr = 0;
                for (int i = 0; i < 4; i++) for (int j = 0; j < 4; j++) sub[i][j] = 0;
                for (int i = 0; i < n; i++) begin
                    if (i != r) begin
                        mc = 0;
                        for (int j = 0; j < n; j++) begin
                            if (j != c) begin
                                sub[mr][mc] = a[i][j];
                                mc++;
                            end
                        end
                        mr++;
                    end
                end
                cof[r][c] = ((r + c) % 2 == 1) ? -det_upto4(sub, n - 1) : det_upto4(sub, n - 1);
            end
        end
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n; c++) begin
                adj = cof[c][r];
                b.row         = IDX_W'(r);
                b.column      = IDX_W'(c);
                b.adjugate    = adj[ADJ_W-1:0];
                b.inverse     = INV_W'((adj * 64'sd65536) / det);
                b.determinant = det[DET_W-1:0];
                b.singular    = 1'b0;
                b.last        = (r == n - 1 && c == n - 1);
                pending_beats.push_back(b);
            end
        end
    endfunction

    task automatic send_element(input logic signed [ELEM_W-1:0] e);
        int gap;
        i_element_valid <= 1'b1;
        i_element       <= e;
        do @(posedge i_clk); while (!o_element_ready);
        absorb_element(e);
        gap = (quiet || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
        if (gap > 0) begin
            i_element_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_order(input logic [CFG_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        order_reg = v;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // The sender stops here until every expected beat is back.
    task automatic wait_drained();
        i_element_valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // This sends one n by n matrix. The style selects random, small, singular or extreme content.
    task automatic send_matrix(input int n, input int style);
        logic signed [ELEM_W-1:0] m[16];
        for (int i = 0; i < n * n; i++) begin
            case (style)
                0: m[i] = ELEM_W'($urandom_range(0, 4095));
                1: m[i] = ELEM_W'($urandom_range(0, 16) - 8);
                2: m[i] = (i >= (n - 1) * n) ? m[i - (n - 1) * n] : ELEM_W'($urandom_range(0, 4095));
                default: m[i] = $urandom_range(0, 1) ? 12'sh800 : 12'sh7ff;
            endcase
        end
        if (style == 2 && n == 1) m[0] = '0;
        for (int i = 0; i < n * n; i++) send_element(m[i]);
    endtask

    task automatic test_directed();
        write_order(3'd1);
        send_element(12'sh7ff);
        send_element(12'sh800);
        send_element(12'sh001);
        send_element(12'sh000);            // singular scalar
        wait_drained();
        write_order(3'd2);
        send_element(12'sh800); send_element(12'sh7ff);
        send_element(12'sh7ff); send_element(12'sh800);
        wait_drained();
        write_order(3'd4);
        for (int i = 0; i < 16; i++) send_element((i % 5 == 0) ? 12'sh800 : 12'sh000);
        wait_drained();
    endtask

    // The order changes in the middle of a load. The count already exceeds the new N*N,
    // so the next element completes the matrix.
    task automatic test_resize_mid_load();
        write_order(3'd4);
        for (int i = 0; i < 5; i++) send_element(ELEM_W'($urandom_range(0, 4095)));
        i_element_valid <= 1'b0;
        write_order(3'd2);
        send_element(ELEM_W'($urandom_range(0, 4095)));
        wait_drained();
    endtask

    // The receiver holds off while the sender keeps offering, so the block backs up.
    task automatic test_backpressure();
        write_order(3'd2);
        hold_request = 1'b1;
        quiet = 1'b1;
        for (int k = 0; k < 3; k++) send_matrix(2, 1);
        quiet = 1'b0;
        wait_drained();
    endtask

    task automatic test_random();
        int               sent;
        logic [CFG_W-1:0] v;
        int               n;
        sent = 0;
        while (sent < 270) begin
            v = CFG_W'($urandom_range(0, 7));
            write_order(v);
            n = order_of(v);
            quiet = ($urandom_range(0, 3) == 0);
            for (int k = $urandom_range(1, 4); k > 0; k--) begin
                send_matrix(n, ($urandom_range(0, 9) < 5) ? 0 : $urandom_range(1, 3));
                sent += n * n;
            end
            wait_drained();
        end
        quiet = 1'b0;
    endtask

    // The result side checks each beat at the edge where it is taken, then draws the next
    // ready value. A long hold-off is counted here once it has been requested.
    initial begin
        int            stall_left;
        int            hold_left;
        t_inverse_beat want;
        stall_left = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_result_valid && i_result_ready) begin
                if (pending_beats.size() == 0) begin
                    $error("result beat with nothing expected");
                    failures++;
                end else begin
                    want = pending_beats.pop_front();
                    if (o_row !== want.row) begin
                        $error("row: expected %0d, got %0d", want.row, o_row); failures++;
                    end
                    if (o_column !== want.column) begin
                        $error("column: expected %0d, got %0d", want.column, o_column);
                        failures++;
                    end
                    if (o_adjugate_entry !== want.adjugate) begin
                        $error("adjugate_entry: expected %0d, got %0d",
                               want.adjugate, o_adjugate_entry);
                        failures++;
                    end
                    if (o_inverse_entry !== want.inverse) begin
                        $error("inverse_entry: expected %0d, got %0d",
                               want.inverse, o_inverse_entry);
                        failures++;
                    end
                    if (o_determinant_value !== want.determinant) begin
                        $error("determinant_value: expected %0d, got %0d",
                               want.determinant, o_determinant_value);
                        failures++;
                    end
                    if (o_singular !== want.singular) begin
                        $error("singular: expected %0d, got %0d", want.singular, o_singular);
                        failures++;
                    end
                    if (o_last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, o_last);
                        failures++;
                    end
                end
            end
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_result_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_result_ready <= 1'b0;
            end else begin
                i_result_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    // The watchdog counts cycles in which nothing is accepted on any channel.
    always @(posedge i_clk) begin
        if ((i_element_valid && o_element_ready) || (i_cfg_valid && o_cfg_ready) ||
            (o_result_valid && i_result_ready)) begin
            watchdog <= 0;
        end else if (watchdog >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            watchdog <= watchdog + 1;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_resize_mid_load();
        test_backpressure();
        test_random();
        wait_drained();
        repeat (200) @(posedge i_clk);
        if (failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
